// ===== rtl/tape_language_core_unit_macros.svh =====
// Assertion macros for the tape language core.
// Both macros use the clock and reset of the module that includes this file.
`ifndef TAPE_LANGUAGE_CORE_UNIT_MACROS_SVH
`define TAPE_LANGUAGE_CORE_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

// The consequent must hold in the same cycle as the antecedent.
`define TLC_ASSERT_NOW(name, pre, post) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("tape_language_core_unit: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define TLC_ASSERT_NEXT(name, pre, post) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("tape_language_core_unit: next-cycle check failed");

`else

`define TLC_ASSERT_NOW(name, pre, post)
`define TLC_ASSERT_NEXT(name, pre, post)

`endif

`endif

// ===== rtl/tlc_pkg.sv =====
`timescale 1ns / 1ps

package tlc_pkg;

   // Sizes of the program, tape and bracket stack.
   localparam int PROG_DEPTH = 4096;
   localparam int PROG_AW    = $clog2(PROG_DEPTH);
   localparam int LEN_W      = $clog2(PROG_DEPTH + 1);
   localparam int TAPE_CELLS = 32768;
   localparam int TAPE_AW    = $clog2(TAPE_CELLS);
   localparam int CELL_BITS  = 8;
   localparam int NEST_DEPTH = 64;
   localparam int NEST_AW    = $clog2(NEST_DEPTH);
   localparam int TOP_W      = $clog2(NEST_DEPTH + 1);

   // Command characters.
   localparam logic [7:0] CH_RIGHT = 8'h3E;
   localparam logic [7:0] CH_LEFT  = 8'h3C;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_OPEN  = 8'h5B;
   localparam logic [7:0] CH_CLOSE = 8'h5D;

   // Item operations.
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_STEP = 1'b1;

   // Result status codes.
   localparam logic [2:0] ST_LOADING = 3'd0;
   localparam logic [2:0] ST_STEPPED = 3'd1;
   localparam logic [2:0] ST_WAITING = 3'd2;
   localparam logic [2:0] ST_HALTED  = 3'd3;
   localparam logic [2:0] ST_ERROR   = 3'd4;

   typedef struct packed {
      logic       operation;
      logic [7:0] program_byte;
      logic       program_last;
      logic [7:0] input_byte;
      logic       input_valid;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_valid;
      logic       input_taken;
      logic [2:0] status;
   } rsp_type;

   // Jump table entry: partner index, plus a flag on an open bracket that
   // starts a clear-cell sequence.
   typedef struct packed {
      logic               idiom;
      logic [PROG_AW-1:0] target;
   } jump_type;

endpackage

// ===== rtl/tape_language_core_unit.sv =====
`timescale 1ns / 1ps
// Channel | Ports                          | Beat carries
// req     | req_valid, req_ready, req_data | one load byte or one step request (req_type)
// rsp     | rsp_valid, rsp_ready, rsp_data | one result per request (rsp_type)
//
// A step that executes a command reads the program byte, jump entry and tape cell from
// synchronous memories in the accept cycle and writes the cell in S_EXEC once the output
// is free. A load beat passes S_DONE; a closing bracket passes S_LPOP and S_LJMP first, as
// the jump table has one write port. Steps that do not execute also pass S_DONE.
// After reset the tape is cleared one cell per cycle, all 32768 cells, with req_ready low.
// A new beat is taken while a result waits; a finished item stalls until the output frees.
`include "tape_language_core_unit_macros.svh"

module tape_language_core_unit
   import tlc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   typedef enum logic [5:0] {
      S_CLEAR = 6'b000001,
      S_IDLE  = 6'b000010,
      S_EXEC  = 6'b000100,
      S_LPOP  = 6'b001000,
      S_LJMP  = 6'b010000,
      S_DONE  = 6'b100000
   } state_type;

   // Control registers.
   state_type            state_ff, state_in;
   logic [TAPE_AW-1:0]   clr_ff, clr_in;
   logic                 ready_ff, ready_in;
   logic                 error_ff, error_in;
   logic [LEN_W-1:0]     len_ff, len_in;
   logic [LEN_W-1:0]     pc_ff, pc_in;
   logic [TAPE_AW-1:0]   dp_ff, dp_in;
   logic [TOP_W-1:0]     top_ff, top_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   // Payload registers.
   req_type              req_ff, req_in;
   logic [PROG_AW-1:0]   at_ff, at_in;
   logic [PROG_AW-1:0]   open_ff, open_in;
   logic                 idiom_cand_ff, idiom_cand_in;
   logic                 prev_dash_ff, prev_dash_in;
   rsp_type              pend_ff, pend_in;
   rsp_type              rsp_ff, rsp_in;

   // Memory ports.
   logic                 prog_wr_en;
   logic [PROG_AW-1:0]   prog_wr_addr;
   logic [7:0]           prog_wr_data;
   logic                 prog_rd_en;
   logic [7:0]           prog_rd_data;
   logic                 jump_wr_en;
   logic [PROG_AW-1:0]   jump_wr_addr;
   jump_type             jump_wr_data;
   logic                 jump_rd_en;
   jump_type             jump_rd_data;
   logic                 stack_wr_en;
   logic [NEST_AW-1:0]   stack_wr_addr;
   logic [PROG_AW-1:0]   stack_wr_data;
   logic                 stack_rd_en;
   logic [NEST_AW-1:0]   stack_rd_addr;
   logic [PROG_AW-1:0]   stack_rd_data;
   logic                 tape_wr_en;
   logic [TAPE_AW-1:0]   tape_wr_addr;
   logic [CELL_BITS-1:0] tape_wr_data;
   logic                 tape_rd_en;
   logic [CELL_BITS-1:0] tape_rd_data;

   // Working values.
   logic                 out_free;
   logic [LEN_W-1:0]     len_eff;
   logic [TOP_W-1:0]     top_eff;
   logic [TOP_W-1:0]     top_v;
   logic                 err_v;
   logic [LEN_W-1:0]     tgt_ext;
   logic [LEN_W-1:0]     jump_after;
   logic [LEN_W-1:0]     npc;
   logic [2:0]           step_status;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // Program bytes and the jump table are addressed by pc while stepping.
   assign prog_rd_en  = jump_rd_en;

   // Target of a taken bracket jump: the command after the partner, or halt.
   assign tgt_ext    = LEN_W'(jump_rd_data.target);
   assign jump_after = (tgt_ext >= len_ff) ? len_ff : tgt_ext + LEN_W'(1);

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      ready_in      = ready_ff;
      error_in      = error_ff;
      len_in        = len_ff;
      pc_in         = pc_ff;
      dp_in         = dp_ff;
      top_in        = top_ff;
      rsp_valid_in  = rsp_valid_ff;
      req_in        = req_ff;
      at_in         = at_ff;
      open_in       = open_ff;
      idiom_cand_in = idiom_cand_ff;
      prev_dash_in  = prev_dash_ff;
      pend_in       = pend_ff;
      rsp_in        = rsp_ff;

      prog_wr_en    = 1'b0;
      prog_wr_addr  = len_ff[PROG_AW-1:0];
      prog_wr_data  = req_data.program_byte;
      jump_wr_en    = 1'b0;
      jump_wr_addr  = at_ff;
      jump_wr_data  = '{idiom: 1'b0, target: open_ff};
      jump_rd_en    = 1'b0;
      stack_wr_en   = 1'b0;
      stack_wr_addr = top_ff[NEST_AW-1:0];
      stack_wr_data = len_ff[PROG_AW-1:0];
      stack_rd_en   = 1'b0;
      stack_rd_addr = top_ff[NEST_AW-1:0];
      tape_wr_en    = 1'b0;
      tape_wr_addr  = dp_ff;
      tape_wr_data  = '0;
      tape_rd_en    = 1'b0;

      len_eff       = ready_ff ? '0 : len_ff;
      top_eff       = ready_ff ? '0 : top_ff;
      top_v         = top_eff;
      err_v         = ready_ff ? 1'b0 : error_ff;
      npc           = pc_ff + LEN_W'(1);
      step_status   = ST_STEPPED;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_CLEAR: begin
            tape_wr_en   = 1'b1;
            tape_wr_addr = clr_ff;
            if (clr_ff == TAPE_AW'(TAPE_CELLS - 1)) begin
               state_in = S_IDLE;
            end else begin
               clr_in = clr_ff + TAPE_AW'(1);
            end
         end

         S_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               state_in = S_DONE;
               pend_in  = '{out_byte: 8'd0, out_valid: 1'b0, input_taken: 1'b0,
                            status: ST_LOADING};
               if (req_data.operation == OP_LOAD) begin
                  // A load after a finished program starts a new one.
                  if (len_eff < LEN_W'(PROG_DEPTH)) begin
                     prog_wr_en    = 1'b1;
                     prog_wr_addr  = len_eff[PROG_AW-1:0];
                     at_in         = len_eff[PROG_AW-1:0];
                     prev_dash_in  = (req_data.program_byte == CH_MINUS);
                     idiom_cand_in = prev_dash_ff;
                     if (req_data.program_byte == CH_OPEN) begin
                        if (top_eff < TOP_W'(NEST_DEPTH)) begin
                           stack_wr_en   = 1'b1;
                           stack_wr_addr = top_eff[NEST_AW-1:0];
                           stack_wr_data = len_eff[PROG_AW-1:0];
                           top_v         = top_eff + TOP_W'(1);
                        end else begin
                           err_v = 1'b1;
                        end
                     end else if (req_data.program_byte == CH_CLOSE) begin
                        if (top_eff == '0) begin
                           err_v = 1'b1;
                        end else begin
                           top_v         = top_eff - TOP_W'(1);
                           stack_rd_en   = 1'b1;
                           stack_rd_addr = top_v[NEST_AW-1:0];
                           state_in      = S_LPOP;
                        end
                     end
                     len_in = len_eff + LEN_W'(1);
                  end else begin
                     len_in = len_eff;
                     err_v  = 1'b1;
                  end
                  if (req_data.program_last) begin
                     if (top_v != '0) begin
                        err_v = 1'b1;
                     end
                     pc_in = '0;
                     dp_in = '0;
                  end
                  ready_in       = req_data.program_last;
                  error_in       = err_v;
                  top_in         = top_v;
                  pend_in.status = err_v ? ST_ERROR : ST_LOADING;
               end else if (!ready_ff) begin
                  pend_in.status = ST_LOADING;
               end else if (error_ff) begin
                  pend_in.status = ST_ERROR;
               end else if (pc_ff >= len_ff) begin
                  pend_in.status = ST_HALTED;
               end else begin
                  jump_rd_en = 1'b1;
                  tape_rd_en = 1'b1;
                  state_in   = S_EXEC;
               end
            end
         end

         S_EXEC: begin
            // Commit only when the output register can take the result.
            if (out_free) begin
               rsp_in = '{out_byte: 8'd0, out_valid: 1'b0, input_taken: 1'b0,
                          status: ST_STEPPED};
               unique case (prog_rd_data)
                  CH_RIGHT: begin
                     dp_in = (dp_ff == TAPE_AW'(TAPE_CELLS - 1)) ? '0 : dp_ff + TAPE_AW'(1);
                  end
                  CH_LEFT: begin
                     dp_in = (dp_ff == '0) ? TAPE_AW'(TAPE_CELLS - 1) : dp_ff - TAPE_AW'(1);
                  end
                  CH_PLUS: begin
                     tape_wr_en   = 1'b1;
                     tape_wr_data = tape_rd_data + CELL_BITS'(1);
                  end
                  CH_MINUS: begin
                     tape_wr_en   = 1'b1;
                     tape_wr_data = tape_rd_data - CELL_BITS'(1);
                  end
                  CH_DOT: begin
                     rsp_in.out_byte  = tape_rd_data[7:0];
                     rsp_in.out_valid = 1'b1;
                  end
                  CH_COMMA: begin
                     if (req_ff.input_valid) begin
                        tape_wr_en         = 1'b1;
                        tape_wr_data       = CELL_BITS'(req_ff.input_byte);
                        rsp_in.input_taken = 1'b1;
                     end else begin
                        npc         = pc_ff;
                        step_status = ST_WAITING;
                     end
                  end
                  CH_OPEN: begin
                     if (jump_rd_data.idiom) begin
                        tape_wr_en = 1'b1;
                        npc        = pc_ff + LEN_W'(3);
                     end else if (tape_rd_data == '0) begin
                        npc = jump_after;
                     end
                  end
                  CH_CLOSE: begin
                     if (tape_rd_data != '0) begin
                        npc = jump_after;
                     end
                  end
                  default: begin
                  end
               endcase
               rsp_in.status = step_status;
               pc_in         = npc;
               rsp_valid_in  = 1'b1;
               state_in      = S_IDLE;
            end
         end

         S_LPOP: begin
            // Opening partner: flag it when the pair encloses a single minus.
            jump_wr_en         = 1'b1;
            jump_wr_addr       = stack_rd_data;
            jump_wr_data.idiom = idiom_cand_ff && (at_ff >= PROG_AW'(2)) &&
                                 (stack_rd_data == at_ff - PROG_AW'(2));
            jump_wr_data.target = at_ff;
            open_in            = stack_rd_data;
            state_in           = S_LJMP;
         end

         S_LJMP: begin
            jump_wr_en = 1'b1;
            state_in   = S_DONE;
         end

         S_DONE: begin
            if (out_free) begin
               rsp_in       = pend_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         ready_ff     <= 1'b0;
         error_ff     <= 1'b0;
         len_ff       <= '0;
         pc_ff        <= '0;
         dp_ff        <= '0;
         top_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         ready_ff     <= ready_in;
         error_ff     <= error_in;
         len_ff       <= len_in;
         pc_ff        <= pc_in;
         dp_ff        <= dp_in;
         top_ff       <= top_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff        <= req_in;
      at_ff         <= at_in;
      open_ff       <= open_in;
      idiom_cand_ff <= idiom_cand_in;
      prev_dash_ff  <= prev_dash_in;
      pend_ff       <= pend_in;
      rsp_ff        <= rsp_in;
   end

   tlc_ram #(.WIDTH(8), .DEPTH(PROG_DEPTH)) u_prog_ram (
      .clock   (clock),
      .wr_en   (prog_wr_en),
      .wr_addr (prog_wr_addr),
      .wr_data (prog_wr_data),
      .rd_en   (prog_rd_en),
      .rd_addr (pc_ff[PROG_AW-1:0]),
      .rd_data (prog_rd_data)
   );

   tlc_ram #(.WIDTH($bits(jump_type)), .DEPTH(PROG_DEPTH)) u_jump_ram (
      .clock   (clock),
      .wr_en   (jump_wr_en),
      .wr_addr (jump_wr_addr),
      .wr_data (jump_wr_data),
      .rd_en   (jump_rd_en),
      .rd_addr (pc_ff[PROG_AW-1:0]),
      .rd_data (jump_rd_data)
   );

   tlc_ram #(.WIDTH(PROG_AW), .DEPTH(NEST_DEPTH)) u_stack_ram (
      .clock   (clock),
      .wr_en   (stack_wr_en),
      .wr_addr (stack_wr_addr),
      .wr_data (stack_wr_data),
      .rd_en   (stack_rd_en),
      .rd_addr (stack_rd_addr),
      .rd_data (stack_rd_data)
   );

   tlc_ram #(.WIDTH(CELL_BITS), .DEPTH(TAPE_CELLS)) u_tape_ram (
      .clock   (clock),
      .wr_en   (tape_wr_en),
      .wr_addr (tape_wr_addr),
      .wr_data (tape_wr_data),
      .rd_en   (tape_rd_en),
      .rd_addr (dp_ff),
      .rd_data (tape_rd_data)
   );

   // A committed step always leaves a result in the output register.
   `TLC_ASSERT_NEXT(a_exec_gives_result, (state_ff == S_EXEC) && out_free, rsp_valid_ff)
   // Results appear only from a finished step or a finished non-executing item.
   `TLC_ASSERT_NOW(a_result_source, $rose(rsp_valid_ff), ($past(state_ff) == S_EXEC) || ($past(state_ff) == S_DONE))
   // The bracket stack never holds more than its depth.
   `TLC_ASSERT_NOW(a_stack_bound, 1'b1, top_ff <= TOP_W'(NEST_DEPTH))
   // In a runnable program the pc never passes the program end.
   `TLC_ASSERT_NOW(a_pc_bound, ready_ff && !error_ff, pc_ff <= len_ff)
   // No new item is taken while an accepted item is still in progress.
   `TLC_ASSERT_NEXT(a_one_item_at_a_time, req_valid && req_ready, !req_ready)

endmodule

// ===== rtl/tlc_ram.sv =====
`timescale 1ns / 1ps

module tlc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Read data holds until the next read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
